FILE: hdl/ble_pkg.sv
// ----------------------------------------------------------------------------
// ble_pkg
// Shared constants and types for the bounded log eviction block: field
// widths, configuration register indexes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ble_pkg;

    // Parameter defaults
    localparam int RING_DEPTH_DEF = 64;
    localparam int LEN_WIDTH_DEF  = 16;

    // Fixed field widths of the ports
    localparam int ENTRY_LEN_W = 16;
    localparam int LIMIT_W     = 7;
    localparam int BYTE_W      = 22;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 22;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT  = 1'd1;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // capture the entry length, clear the eviction tally
        logic pop;      // drop the oldest entry
        logic append;   // append the entry and load the result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_pop; // a limit still forces the oldest entry out
    } t_dp_sts;

endpackage : ble_pkg

`default_nettype wire

FILE: hdl/ble_ram.sv
// ----------------------------------------------------------------------------
// ble_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule : ble_ram

`default_nettype wire

FILE: hdl/ble_ctrl.sv
// ----------------------------------------------------------------------------
// ble_ctrl
// Controller: takes one transaction at a time, steps the datapath through
// its evictions one per cycle, then appends and hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_ready,
    input  wire ble_pkg::t_dp_sts i_sts,
    output ble_pkg::t_dp_cmd      o_cmd
);

    import ble_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_EVICT = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EVICT;
                end
            end
            ST_EVICT: begin
                if (i_sts.need_pop) begin
                    o_cmd.pop = 1'b1;
                end else if (out_free) begin
                    o_cmd.append = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_out_valid = o_cmd.append || (r_out_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;

endmodule : ble_ctrl

`default_nettype wire

FILE: hdl/ble_dp.sv
// ----------------------------------------------------------------------------
// ble_dp
// Datapath: configuration registers, ring pointers, running count and total,
// the length ring itself and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_dp #(
    parameter int RING_DEPTH = ble_pkg::RING_DEPTH_DEF,
    parameter int LEN_WIDTH  = ble_pkg::LEN_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [ble_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ble_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [ble_pkg::ENTRY_LEN_W-1:0]  i_entry_len,
    input  wire ble_pkg::t_dp_cmd                 i_cmd,
    output ble_pkg::t_dp_sts                      o_sts,
    output logic      [ble_pkg::LIMIT_W-1:0]      o_evicted_count,
    output logic      [ble_pkg::LIMIT_W-1:0]      o_count_after,
    output logic      [ble_pkg::BYTE_W-1:0]       o_total_after
);

    import ble_pkg::*;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int TOT_W = LEN_WIDTH + CNT_W;
    localparam int CMP_W = (TOT_W + 1 > BYTE_W) ? TOT_W + 1 : BYTE_W;
    localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    logic [LIMIT_W-1:0]   r_entry_limit;
    logic [BYTE_W-1:0]    r_byte_limit;
    logic [IDX_W-1:0]     r_head, n_head;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [TOT_W-1:0]     r_total, n_total;
    logic [LEN_WIDTH-1:0] r_len;
    logic [CNT_W-1:0]     r_evicted;
    logic [LIMIT_W-1:0]   r_out_evicted;
    logic [LIMIT_W-1:0]   r_out_count;
    logic [BYTE_W-1:0]    r_out_total;

    logic [31:0]          len_ext;
    logic [LEN_WIDTH-1:0] rd_len;
    logic [SUM_W-1:0]     tail_sum;
    logic [IDX_W-1:0]     tail_idx;
    logic [IDX_W-1:0]     head_inc;
    logic [LIM_W-1:0]     eff_limit;
    logic                 count_full;
    logic [CMP_W-1:0]     byte_sum;
    logic                 byte_over;
    logic [CNT_W-1:0]     count_app;
    logic [TOT_W-1:0]     total_app;
    logic [CNT_W+LIMIT_W-1:0] evicted_ext;
    logic [CNT_W+LIMIT_W-1:0] count_ext;
    logic [TOT_W+BYTE_W-1:0]  total_ext;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_limit <= '0;
            r_byte_limit  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENTRY_LIMIT: r_entry_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_BYTE_LIMIT:  r_byte_limit  <= i_cfg_data[BYTE_W-1:0];
            endcase
        end
    end

    assign len_ext = {16'd0, i_entry_len};

    // Eviction decision
    always_comb begin
        if (r_entry_limit != '0 && LIM_W'(r_entry_limit) < LIM_W'(RING_DEPTH)) begin
            eff_limit = LIM_W'(r_entry_limit);
        end else begin
            eff_limit = LIM_W'(RING_DEPTH);
        end
    end

    assign count_full = (r_count != '0) && (LIM_W'(r_count) >= eff_limit);
    assign byte_sum   = CMP_W'(r_total) + CMP_W'(r_len);
    assign byte_over  = (r_byte_limit != '0) && (r_count != '0) &&
                        (byte_sum > CMP_W'(r_byte_limit));
    assign o_sts.need_pop = count_full || byte_over;

    // Ring addressing: wrap without relying on a power-of-two depth
    assign head_inc = (r_head == IDX_W'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
    assign tail_idx = (tail_sum >= SUM_W'(RING_DEPTH)) ?
                      IDX_W'(tail_sum - SUM_W'(RING_DEPTH)) : IDX_W'(tail_sum);

    assign count_app = r_count + 1'b1;
    assign total_app = r_total + TOT_W'(r_len);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_total = r_total;
        if (i_cmd.pop) begin
            n_head  = head_inc;
            n_count = r_count - 1'b1;
            n_total = r_total - TOT_W'(rd_len);
        end else if (i_cmd.append) begin
            n_count = count_app;
            n_total = total_app;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_total <= n_total;
        end
    end

    // Per-transaction working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_len     <= len_ext[LEN_WIDTH-1:0];
            r_evicted <= '0;
        end else if (i_cmd.pop) begin
            r_evicted <= r_evicted + 1'b1;
        end
    end

    // Read the head that will stand next cycle, so its length is ready for a pop
    ble_ram #(
        .WIDTH (LEN_WIDTH),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.append),
        .i_wr_addr (tail_idx),
        .i_wr_data (r_len),
        .i_rd_addr (n_head),
        .o_rd_data (rd_len)
    );

    // Result register, truncated to the field widths
    assign evicted_ext = {{LIMIT_W{1'b0}}, r_evicted};
    assign count_ext   = {{LIMIT_W{1'b0}}, count_app};
    assign total_ext   = {{BYTE_W{1'b0}}, total_app};

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_out_evicted <= evicted_ext[LIMIT_W-1:0];
            r_out_count   <= count_ext[LIMIT_W-1:0];
            r_out_total   <= total_ext[BYTE_W-1:0];
        end
    end

    assign o_evicted_count = r_out_evicted;
    assign o_count_after   = r_out_count;
    assign o_total_after   = r_out_total;

endmodule : ble_dp

`default_nettype wire

FILE: hdl/bounded_log_eviction.sv
// ----------------------------------------------------------------------------
// bounded_log_eviction
// Ring of entry lengths with an entry limit and a byte limit; evicts the
// oldest entries before each append and reports count and total.
// ----------------------------------------------------------------------------
// One append runs in steps from acceptance to its result being registered,
// where E is the number of entries it evicts: the transaction is taken, then
// E evictions follow (the head length comes from the ring RAM's registered
// read port, one entry per cycle), then the entry is appended once the output
// register is free. The block holds one transaction at a time; the result
// waits in an output register, and the next transaction is taken while it
// waits. The ring contents are not cleared at reset and need no clearing
// pass: only written entries are ever evicted. Configuration writes are
// always ready and must arrive while the block is idle.
`default_nettype none

module bounded_log_eviction #(
    parameter int RING_DEPTH = ble_pkg::RING_DEPTH_DEF,
    parameter int LEN_WIDTH  = ble_pkg::LEN_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ble_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ble_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [ble_pkg::ENTRY_LEN_W-1:0] i_entry_len,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic      [ble_pkg::LIMIT_W-1:0]     o_evicted_count,
    output logic      [ble_pkg::LIMIT_W-1:0]     o_count_after,
    output logic      [ble_pkg::BYTE_W-1:0]      o_total_after
);

    import ble_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    ble_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ble_dp #(
        .RING_DEPTH (RING_DEPTH),
        .LEN_WIDTH  (LEN_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_entry_len     (i_entry_len),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_evicted_count (o_evicted_count),
        .o_count_after   (o_count_after),
        .o_total_after   (o_total_after)
    );

endmodule : bounded_log_eviction

`default_nettype wire

FILE: hdl/ble_checker.sv
// ----------------------------------------------------------------------------
// ble_checker
// Port-level checks on the bounded log eviction block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_valid,
    input wire logic                            o_ready,
    input wire logic                            o_valid,
    input wire logic                            i_ready,
    input wire logic [ble_pkg::LIMIT_W-1:0]     o_evicted_count,
    input wire logic [ble_pkg::LIMIT_W-1:0]     o_count_after,
    input wire logic [ble_pkg::BYTE_W-1:0]      o_total_after
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_evicted_count) &&
        $stable(o_count_after) && $stable(o_total_after))
        else $error("result changed while stalled");

    // Reset drops any pending result
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // An accepted transaction closes the input until its work is done
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input open right after a transaction");

    // Every append leaves at least the new entry held
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_count_after != '0)
        else $error("result reports an empty ring");

endmodule : ble_checker

bind bounded_log_eviction ble_checker u_ble_checker (.*);

`default_nettype wire
